// ===== rtl/mmlas_pkg.sv =====
// shared types and constants of the merkle multi-leaf authentication set core
package mmlas_pkg;

  localparam int MAX_HEIGHT = 32;
  localparam int LEAF_W     = 32;
  localparam int LEVEL_W    = 5;
  localparam int HEIGHT_W   = 6;
  localparam int DEPTH_W    = 6;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 6'd16;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 6'd32;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 6'd1;

  // error codes of a result
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_ORDER = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_FINAL,
    ST_FLUSH,
    ST_ERR
  } state_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic accept;      // latch a new leaf and run the entry checks
    logic step;        // advance to the next level
    logic pop;         // drop the top of the level stack
    logic push;        // push the current level onto the stack
    logic emit;        // emit the sibling node of the current level
    logic load_final;  // start the final path walk
    logic flush;       // send the held node as last, or the empty result
    logic err_out;     // send the error result
    logic clear_run;   // discard the set state
  } dp_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic acc_err;     // incoming leaf is out of range or out of order
    logic acc_diff;    // incoming leaf differs from the stored one
    logic acc_fin;     // incoming leaf ends the set
    logic more;        // common parent walk has levels left
    logic top_hit;     // stack top holds the current level
    logic final_last;  // current level is the top path level
    logic out_free;    // output register can take a transaction
    logic can_emit;    // an emitted node has a place to go
    logic fin;         // current leaf ends the set
  } dp_sts_t;

endpackage

// ===== rtl/mmlas_ctrl.sv =====
// sequencer of the authentication set walk
module mmlas_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mmlas_pkg::dp_sts_t sts,
  output mmlas_pkg::dp_cmd_t cmd
);
  import mmlas_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.acc_err) begin
            state_nxt = ST_ERR;
          end else if (sts.acc_diff) begin
            state_nxt = ST_DIFF;
          end else if (sts.acc_fin) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_DIFF: begin
        if (!sts.more) begin
          // reached the common parent: record its level
          cmd.push = 1'b1;
          if (sts.fin) begin
            cmd.load_final = 1'b1;
            state_nxt      = ST_FINAL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (sts.top_hit) begin
          cmd.pop  = 1'b1;
          cmd.step = 1'b1;
        end else if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.step = 1'b1;
        end
      end
      ST_FINAL: begin
        if (sts.top_hit) begin
          cmd.pop  = 1'b1;
          cmd.step = 1'b1;
          if (sts.final_last) begin
            state_nxt = ST_FLUSH;
          end
        end else if (sts.can_emit) begin
          cmd.emit = 1'b1;
          cmd.step = 1'b1;
          if (sts.final_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush     = 1'b1;
          cmd.clear_run = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.err_out = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mmlas_dp.sv =====
// datapath: leaf state, level stack, path shifters and output register
module mmlas_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [mmlas_pkg::HEIGHT_W-1:0]  cfg_tree_height,
  input  logic [mmlas_pkg::LEAF_W-1:0]    in_leaf_index,
  input  logic                            in_final_leaf,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [mmlas_pkg::LEVEL_W-1:0]   out_node_level,
  output logic [mmlas_pkg::LEAF_W-1:0]    out_node_index,
  output logic                            out_last_node,
  output logic                            out_set_empty,
  output logic [1:0]                      out_error_code,
  input  mmlas_pkg::dp_cmd_t              cmd,
  output mmlas_pkg::dp_sts_t              sts
);
  import mmlas_pkg::*;

  logic [HEIGHT_W-1:0] tree_height_r;
  logic [LEAF_W-1:0]   prev_r;
  logic                have_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [LEVEL_W-1:0]  stack_r [MAX_HEIGHT];
  logic [LEAF_W-1:0]   leaf_r;
  logic                fin_r;
  logic [HEIGHT_W-1:0] h_r;
  logic [LEVEL_W-1:0]  j_r;
  logic [LEAF_W-1:0]   sh_r;
  logic [LEAF_W-1:0]   x_r;
  logic [1:0]          err_r;
  logic                pend_v_r;
  logic [LEVEL_W-1:0]  pend_lvl_r;
  logic [LEAF_W-1:0]   pend_idx_r;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  out_lvl_r;
  logic [LEAF_W-1:0]   out_idx_r;
  logic                out_last_r;
  logic                out_empty_r;
  logic [1:0]          out_err_r;

  logic [HEIGHT_W-1:0] h_clamp;
  logic [LEAF_W-1:0]   hi_mask;
  logic                range_err;
  logic                order_err;
  logic                out_free;
  logic [LEVEL_W-1:0]  top_idx;
  logic [LEAF_W-1:0]   node_idx;

  // effective height and entry checks
  always_comb begin
    if (tree_height_r == '0) begin
      h_clamp = HEIGHT_MIN;
    end else if (tree_height_r > HEIGHT_MAX) begin
      h_clamp = HEIGHT_MAX;
    end else begin
      h_clamp = tree_height_r;
    end
  end

  assign hi_mask   = ~((LEAF_W'(1) << h_clamp[LEVEL_W-1:0]) - LEAF_W'(1));
  assign range_err = !h_clamp[HEIGHT_W-1] && (|(in_leaf_index & hi_mask));
  assign order_err = have_r && (in_leaf_index < prev_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign top_idx   = LEVEL_W'(depth_r - DEPTH_W'(1));
  assign node_idx  = sh_r ^ LEAF_W'(1);

  // status to the sequencer
  always_comb begin
    sts            = '0;
    sts.acc_err    = range_err || order_err;
    sts.acc_diff   = have_r && (in_leaf_index != prev_r);
    sts.acc_fin    = in_final_leaf;
    sts.more       = |x_r[LEAF_W-1:1];
    sts.top_hit    = (depth_r != '0) && (stack_r[top_idx] == j_r);
    sts.final_last = ({1'b0, j_r} == (h_r - HEIGHT_W'(1)));
    sts.out_free   = out_free;
    sts.can_emit   = fin_r ? (!pend_v_r || out_free) : out_free;
    sts.fin        = fin_r;
  end

  // height register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      tree_height_r <= cfg_tree_height;
    end
  end

  // run state: stored leaf and stack depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      have_r  <= 1'b0;
      depth_r <= '0;
    end else if (cmd.accept) begin
      if (range_err || order_err) begin
        prev_r  <= '0;
        have_r  <= 1'b0;
        depth_r <= '0;
      end else begin
        prev_r <= in_leaf_index;
        have_r <= 1'b1;
      end
    end else if (cmd.clear_run) begin
      prev_r  <= '0;
      have_r  <= 1'b0;
      depth_r <= '0;
    end else if (cmd.pop) begin
      depth_r <= depth_r - DEPTH_W'(1);
    end else if (cmd.push && !depth_r[DEPTH_W-1]) begin
      depth_r <= depth_r + DEPTH_W'(1);
    end
  end

  // level stack, no reset: entries are read only below the depth
  always_ff @(posedge clk) begin
    if (cmd.push && !depth_r[DEPTH_W-1]) begin
      stack_r[depth_r[LEVEL_W-1:0]] <= j_r;
    end
  end

  // walk registers: level counter and shifted leaf words
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      leaf_r <= in_leaf_index;
      fin_r  <= in_final_leaf;
      h_r    <= h_clamp;
      j_r    <= '0;
      x_r    <= prev_r ^ in_leaf_index;
      sh_r   <= (have_r && (in_leaf_index != prev_r)) ? prev_r : in_leaf_index;
      err_r  <= range_err ? ERR_RANGE : ERR_ORDER;
    end else if (cmd.load_final) begin
      j_r  <= '0;
      sh_r <= leaf_r;
    end else if (cmd.step) begin
      j_r  <= j_r + LEVEL_W'(1);
      sh_r <= sh_r >> 1;
      x_r  <= x_r >> 1;
    end
  end

  // held node of the final step, so the last one can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.emit && fin_r) begin
      pend_v_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && fin_r) begin
      pend_lvl_r <= j_r;
      pend_idx_r <= node_idx;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.emit && (!fin_r || pend_v_r)) || cmd.flush || cmd.err_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit && !fin_r) begin
      out_lvl_r   <= j_r;
      out_idx_r   <= node_idx;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b0;
      out_err_r   <= ERR_NONE;
    end else if (cmd.emit && pend_v_r) begin
      out_lvl_r   <= pend_lvl_r;
      out_idx_r   <= pend_idx_r;
      out_last_r  <= 1'b0;
      out_empty_r <= 1'b0;
      out_err_r   <= ERR_NONE;
    end else if (cmd.flush) begin
      out_lvl_r   <= pend_v_r ? pend_lvl_r : '0;
      out_idx_r   <= pend_v_r ? pend_idx_r : '0;
      out_last_r  <= 1'b1;
      out_empty_r <= !pend_v_r;
      out_err_r   <= ERR_NONE;
    end else if (cmd.err_out) begin
      out_lvl_r   <= '0;
      out_idx_r   <= '0;
      out_last_r  <= 1'b1;
      out_empty_r <= 1'b0;
      out_err_r   <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node_level = out_lvl_r;
  assign out_node_index = out_idx_r;
  assign out_last_node  = out_last_r;
  assign out_set_empty  = out_empty_r;
  assign out_error_code = out_err_r;

endmodule

// ===== rtl/merkle_multi_leaf_auth_set_core.sv =====
// top level of the merkle multi-leaf authentication set core
// Leaf indices of one set enter in ascending order, the last one flagged by
// in_final_leaf; the core returns the authentication nodes (level, index) the
// set needs, the last one flagged by out_last_node. The sequencer walks one
// tree level per cycle while the output can take the nodes it emits, first up
// to the common parent with the previous leaf and, for a final leaf, then
// along the path of that leaf up to the effective tree height before it sends
// the last node. cfg_tree_height is always taken; write it between sets.
module merkle_multi_leaf_auth_set_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mmlas_pkg::HEIGHT_W-1:0]  cfg_tree_height,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mmlas_pkg::LEAF_W-1:0]    in_leaf_index,
  input  logic                            in_final_leaf,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mmlas_pkg::LEVEL_W-1:0]   out_node_level,
  output logic [mmlas_pkg::LEAF_W-1:0]    out_node_index,
  output logic                            out_last_node,
  output logic                            out_set_empty,
  output logic [1:0]                      out_error_code
);
  import mmlas_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // height register accepts a transaction every cycle
  assign cfg_ready = 1'b1;

  // sequencer
  mmlas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  mmlas_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_tree_height (cfg_tree_height),
    .in_leaf_index   (in_leaf_index),
    .in_final_leaf   (in_final_leaf),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_node_level  (out_node_level),
    .out_node_index  (out_node_index),
    .out_last_node   (out_last_node),
    .out_set_empty   (out_set_empty),
    .out_error_code  (out_error_code),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== rtl/mmlas_checker.sv =====
// port-level checks of the authentication set core, bound to the top level
module mmlas_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [mmlas_pkg::LEVEL_W-1:0]   out_node_level,
  input logic [mmlas_pkg::LEAF_W-1:0]    out_node_index,
  input logic                            out_last_node,
  input logic                            out_set_empty,
  input logic [1:0]                      out_error_code
);
  import mmlas_pkg::*;

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset leaves the core ready for a leaf
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_node_index) &&
      $stable(out_node_level) && $stable(out_last_node))
    else $error("stalled output transaction changed");

  // error transaction closes the set with zero fields
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |->
      out_last_node && !out_set_empty && (out_node_level == '0) &&
      (out_node_index == '0) &&
      ((out_error_code == ERR_ORDER) || (out_error_code == ERR_RANGE)))
    else $error("malformed error transaction");

  // empty set marker closes the set with zero fields
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_set_empty |->
      out_last_node && (out_error_code == ERR_NONE) &&
      (out_node_level == '0) && (out_node_index == '0))
    else $error("malformed empty set transaction");

endmodule

bind merkle_multi_leaf_auth_set_core mmlas_checker u_mmlas_checker (.*);
